// File: rtl/wssl_pkg.sv
// Package for the word stream search unit: payload structs, register codes
// and the byte classification helpers used by the front end.
// No dependencies.
package wssl_pkg;

  localparam int TARGET_BYTES = 16;
  localparam int TIDX_W       = 7;
  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic        match_found;
    logic [31:0] match_offset;
    logic [31:0] longest_length;
    logic [31:0] longest_offset;
  } result_t;

  // One classified byte, handed from the front end to the back end.
  typedef struct packed {
    logic is_sep;
    logic mismatch;
    logic last;
  } class_item_t;

  typedef enum logic [1:0] {
    REG_TARGET_LOW  = 2'd0,
    REG_TARGET_HIGH = 2'd1,
    REG_TARGET_LEN  = 2'd2
  } cfg_reg_e;

  // Whitespace or punctuation in the C locale.
  function automatic logic is_separator(input logic [7:0] b);
    is_separator = (b >= 8'd9   && b <= 8'd13)  ||
                   (b >= 8'd32  && b <= 8'd47)  ||
                   (b >= 8'd58  && b <= 8'd64)  ||
                   (b >= 8'd91  && b <= 8'd96)  ||
                   (b >= 8'd123 && b <= 8'd126);
  endfunction

  // Target byte at a position; positions past the stored bytes read as zero.
  function automatic logic [7:0] target_byte(input logic [8*TARGET_BYTES-1:0] t,
                                             input logic [TIDX_W-1:0] idx);
    if (idx < TIDX_W'(TARGET_BYTES))
      target_byte = t[8*idx[3:0] +: 8];
    else
      target_byte = 8'd0;
  endfunction

endpackage

// File: rtl/wssl_front.sv
// Front end: accepts text bytes, classifies them and compares each word byte
// with the target at its position in the word. Depends on wssl_pkg.
module wssl_front #(
  parameter int MAX_TARGET_LEN = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  wssl_pkg::text_item_t                    in_item,
  input  logic [8*wssl_pkg::TARGET_BYTES-1:0]     tgt_bytes,
  input  logic [4:0]                              tgt_len,
  output wssl_pkg::class_item_t                   cls
);
  import wssl_pkg::*;

  localparam int PW = $clog2(MAX_TARGET_LEN + 1);

  logic          in_word;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_use;
  logic [PW-1:0] pos_next;
  logic          sep;

  assign sep     = is_separator(in_item.text_byte);
  assign pos_use = in_word ? pos : '0;
  // Saturate at the limit: any position at or past it already mismatches.
  assign pos_next = (32'(pos_use) >= 32'(MAX_TARGET_LEN)) ? PW'(MAX_TARGET_LEN)
                                                           : pos_use + PW'(1);

  assign cls.is_sep   = sep;
  assign cls.last     = in_item.end_of_text;
  assign cls.mismatch = (32'(pos_use) >= 32'(tgt_len)) ||
                        (32'(pos_use) >= 32'(MAX_TARGET_LEN)) ||
                        (in_item.text_byte != target_byte(tgt_bytes, TIDX_W'(pos_use)));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word <= 1'b0;
      pos     <= '0;
    end else if (accept) begin
      if (sep || in_item.end_of_text) begin
        in_word <= 1'b0;
        pos     <= '0;
      end else begin
        in_word <= 1'b1;
        pos     <= pos_next;
      end
    end
  end

endmodule

// File: rtl/wssl_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on wssl_pkg.
module wssl_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  wssl_pkg::class_item_t  wr_item,
  output logic                   full,
  input  logic                   rd_en,
  output logic                   rd_valid,
  output wssl_pkg::class_item_t  rd_item
);
  import wssl_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  class_item_t   slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/wssl_back.sv
// Back end: word tracking, first match and longest word bookkeeping, and the
// result register. Depends on wssl_pkg.
module wssl_back #(
  parameter int MAX_TARGET_LEN = 16,
  parameter int OFFSET_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  wssl_pkg::class_item_t  q_item,
  output logic                   q_pop,
  input  logic [4:0]             tgt_len,
  output logic                   res_valid,
  output wssl_pkg::result_t      res,
  input  logic                   res_pop
);
  import wssl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CMAX = '1;

  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   inside_word;
  logic [OFFSET_BITS-1:0] word_start;
  logic [OFFSET_BITS-1:0] run_length;
  logic                   word_mismatch;
  logic                   found_flag;
  logic [OFFSET_BITS-1:0] found_offset;
  logic [OFFSET_BITS-1:0] best_length;
  logic [OFFSET_BITS-1:0] best_offset;

  logic                   is_word;
  logic                   step;
  logic                   inside_word_next;
  logic [OFFSET_BITS-1:0] word_start_next;
  logic [OFFSET_BITS-1:0] run_length_next;
  logic                   word_mismatch_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic                   close_en;
  logic [OFFSET_BITS-1:0] cw_start;
  logic [OFFSET_BITS-1:0] cw_length;
  logic                   cw_mismatch;
  logic                   hit;
  logic                   longer;
  logic                   found_flag_next;
  logic [OFFSET_BITS-1:0] found_offset_next;
  logic [OFFSET_BITS-1:0] best_length_next;
  logic [OFFSET_BITS-1:0] best_offset_next;
  logic [63:0]            found_w;
  logic [63:0]            blen_w;
  logic [63:0]            boff_w;

  // Advance every non-final byte; hold a final byte while the result register
  // is occupied and not being emptied this cycle.
  assign step  = q_valid && (!q_item.last || !res_valid || res_pop);
  assign q_pop = step;

  assign is_word          = !q_item.is_sep;
  assign byte_offset_next = (byte_offset == CMAX) ? byte_offset
                                                  : byte_offset + OFFSET_BITS'(1);

  always_comb begin
    inside_word_next   = inside_word;
    word_start_next    = word_start;
    run_length_next    = run_length;
    word_mismatch_next = word_mismatch;
    if (is_word) begin
      inside_word_next = 1'b1;
      if (inside_word) begin
        run_length_next    = (run_length == CMAX) ? run_length
                                                  : run_length + OFFSET_BITS'(1);
        word_mismatch_next = word_mismatch | q_item.mismatch;
      end else begin
        word_start_next    = byte_offset;
        run_length_next    = OFFSET_BITS'(1);
        word_mismatch_next = q_item.mismatch;
      end
    end else begin
      inside_word_next = 1'b0;
    end
  end

  // A separator closes the word before it; a final word byte closes its own word.
  assign close_en    = is_word ? q_item.last : inside_word;
  assign cw_start    = is_word ? word_start_next    : word_start;
  assign cw_length   = is_word ? run_length_next    : run_length;
  assign cw_mismatch = is_word ? word_mismatch_next : word_mismatch;

  assign hit = close_en && !found_flag && (tgt_len != 5'd0) &&
               (32'(tgt_len) <= 32'(MAX_TARGET_LEN)) && !cw_mismatch &&
               (64'(cw_length) == 64'(tgt_len));
  assign longer = close_en && (cw_length > best_length);

  assign found_flag_next   = found_flag | hit;
  assign found_offset_next = hit    ? cw_start  : found_offset;
  assign best_length_next  = longer ? cw_length : best_length;
  assign best_offset_next  = longer ? cw_start  : best_offset;

  assign found_w = 64'(found_offset_next);
  assign blen_w  = 64'(best_length_next);
  assign boff_w  = 64'(best_offset_next);

  always_ff @(posedge clk) begin
    if (step && q_item.last) begin
      res.match_found    <= found_flag_next;
      res.match_offset   <= found_flag_next ? found_w[31:0] : 32'd0;
      res.longest_length <= blen_w[31:0];
      res.longest_offset <= boff_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      byte_offset   <= '0;
      inside_word   <= 1'b0;
      word_start    <= '0;
      run_length    <= '0;
      word_mismatch <= 1'b0;
      found_flag    <= 1'b0;
      found_offset  <= '0;
      best_length   <= '0;
      best_offset   <= '0;
    end else begin
      if (step && q_item.last) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      if (step) begin
        if (q_item.last) begin
          byte_offset   <= '0;
          inside_word   <= 1'b0;
          word_start    <= '0;
          run_length    <= '0;
          word_mismatch <= 1'b0;
          found_flag    <= 1'b0;
          found_offset  <= '0;
          best_length   <= '0;
          best_offset   <= '0;
        end else begin
          byte_offset   <= byte_offset_next;
          inside_word   <= inside_word_next;
          word_start    <= word_start_next;
          run_length    <= run_length_next;
          word_mismatch <= word_mismatch_next;
          found_flag    <= found_flag_next;
          found_offset  <= found_offset_next;
          best_length   <= best_length_next;
          best_offset   <= best_offset_next;
        end
      end
    end
  end

endmodule

// File: rtl/word_stream_search_longest_unit.sv
// Word stream search, top level: configuration registers, front end, queue
// and back end. Depends on wssl_pkg, wssl_front, wssl_queue, wssl_back.
//
// Usage:
//   Input channel (push/full, in_item): one text byte per beat, with
//   end_of_text set on the final byte of a stream. Bytes are split into
//   words at C-locale whitespace and punctuation.
//   Result channel (empty/pop, out_item): one beat per stream, carrying the
//   first whole-word match of the target and the first longest word (offset
//   and length). Offsets and lengths saturate at the counter width.
//   Configuration (cfg_write, cfg_index, cfg_data): target bytes low, target
//   bytes high, target length; write only while no stream is in flight.
// Throughput: one byte per clock, unless a final byte waits on a result
//   not yet popped. Path: the final byte is written into the queue, then
//   the back end pops it and loads the result register behind out_item.
// Reset: clear all stream state, the queue and the result valid flag; the
//   target registers return to zero (no match). No clearing pass.
// Stall: a result not popped holds on out_item; the back end keeps working
//   until the next final byte, then the two-entry queue fills and full rises.
module word_stream_search_longest_unit #(
  parameter int MAX_TARGET_LEN = 16,
  parameter int OFFSET_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  wssl_pkg::text_item_t in_item,
  output logic                 empty,
  input  logic                 pop,
  output wssl_pkg::result_t    out_item,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import wssl_pkg::*;

  logic [63:0]  target_low;
  logic [63:0]  target_high;
  logic [4:0]   target_len;
  logic         accept;
  class_item_t  cls;
  logic         q_valid;
  logic         q_pop;
  class_item_t  q_item;
  logic         res_valid;

  // Hold the target; an index outside the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_low  <= '0;
      target_high <= '0;
      target_len  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_LOW:  target_low  <= cfg_data;
        REG_TARGET_HIGH: target_high <= cfg_data;
        REG_TARGET_LEN:  target_len  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  wssl_front #(
    .MAX_TARGET_LEN (MAX_TARGET_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .tgt_bytes ({target_high, target_low}),
    .tgt_len   (target_len),
    .cls       (cls)
  );

  wssl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_item  (cls),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  wssl_back #(
    .MAX_TARGET_LEN (MAX_TARGET_LEN),
    .OFFSET_BITS    (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .tgt_len   (target_len),
    .res_valid (res_valid),
    .res       (out_item),
    .res_pop   (pop)
  );

  assign empty = !res_valid;

endmodule

// File: rtl/wssl_checker.sv
// Port-level checks for the word stream search unit, bound to its top level.
// Depends on wssl_pkg.
module wssl_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input wssl_pkg::result_t out_item
);
  import wssl_pkg::*;

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("result or full pending after reset");

  // A waiting result beat holds until popped.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("result beat changed before pop");

  // No match means no match offset.
  a_no_match_offset: assert property (@(posedge clk) disable iff (rst)
    !empty && !out_item.match_found |-> out_item.match_offset == 32'd0)
    else $error("match offset set without a match");

  // No words means no longest offset and no match.
  a_no_words: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.longest_length == 32'd0 |->
      out_item.longest_offset == 32'd0 && !out_item.match_found)
    else $error("word reported in a stream without words");

endmodule

bind word_stream_search_longest_unit wssl_checker u_wssl_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

// File: verif/word_stream_search_longest_unit_test.sv
// Self-checking bench for word_stream_search_longest_unit: text streams go in
// one byte per beat, each summary beat is checked against a local scan model.
// Depends on wssl_pkg and the unit RTL; needs no files or arguments.
module word_stream_search_longest_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wssl_pkg::*;

  localparam int WORD_LIMIT   = 16;    // longest target the unit can match
  localparam int RANDOM_BYTES = 700;
  localparam int MIN_STREAMS  = 48;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_LIMIT   = 1000;  // cycles with no beat on either side
  localparam logic [31:0] COUNT_MAX = '1;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  text_item_t  in_item;
  logic        empty;
  logic        pop;
  result_t     out_item;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  word_stream_search_longest_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Scan model: own copy of the target registers and of the per-stream state.
  // ---------------------------------------------------------------------------
  logic [127:0] tgt_bytes;
  logic [4:0]   tgt_len;

  logic [31:0] pos;          // offset of the next byte in the stream
  logic        in_word;
  logic [31:0] word_start;
  logic [31:0] word_len;
  logic        word_bad;     // current word has already diverged from target
  logic        found;
  logic [31:0] found_at;
  logic [31:0] best_len;
  logic [31:0] best_at;

  result_t awaited_summaries[$];

  logic [7:0] stream_buf[$];  // bytes of the stream being built

  logic sender_idles;
  logic reader_idles;
  int   n_bytes;
  int   n_streams;
  int   n_targets;
  int   n_results;
  int   n_matches;
  int   n_mismatches;
  int   idle_cycles;

  // Whitespace, or printable ASCII that is neither a digit nor a letter.
  function automatic logic breaks_word(input logic [7:0] b);
    return (b >= 8'd9 && b <= 8'd13) ||
           (b >= 8'd32 && b <= 8'd126 &&
            !(b >= 8'd48 && b <= 8'd57) &&
            !(b >= 8'd65 && b <= 8'd90) &&
            !(b >= 8'd97 && b <= 8'd122));
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  // Target byte at a word position; nothing is stored past byte fifteen.
  function automatic logic [7:0] target_at(input logic [31:0] idx);
    logic [127:0] shifted;
    shifted = tgt_bytes >> (8 * idx[3:0]);
    return (idx < 32'd16) ? shifted[7:0] : 8'h00;
  endfunction

  task automatic clear_scan();
    pos        = '0;
    in_word    = 1'b0;
    word_start = '0;
    word_len   = '0;
    word_bad   = 1'b0;
    found      = 1'b0;
    found_at   = '0;
    best_len   = '0;
    best_at    = '0;
  endtask

  // Close an open word: note the first whole-word match and the first
  // strictly longest word.
  task automatic end_current_word();
    if (!in_word) return;
    if (!found && tgt_len != 5'd0 && int'(tgt_len) <= WORD_LIMIT && !word_bad &&
        word_len == 32'(tgt_len)) begin
      found    = 1'b1;
      found_at = word_start;
    end
    if (word_len > best_len) begin
      best_len = word_len;
      best_at  = word_start;
    end
    in_word = 1'b0;
  endtask

  // Advance the model by one accepted byte; queue a summary on the final byte.
  task automatic scan_text_byte(input text_item_t it);
    result_t summary;
    if (!breaks_word(it.text_byte)) begin
      if (!in_word) begin
        in_word    = 1'b1;
        word_start = pos;
        word_len   = '0;
        word_bad   = 1'b0;
      end
      if (word_len >= 32'(tgt_len) || word_len >= WORD_LIMIT ||
          it.text_byte != target_at(word_len))
        word_bad = 1'b1;
      word_len = bump(word_len);
    end else begin
      end_current_word();
    end
    pos = bump(pos);
    if (it.end_of_text) begin
      end_current_word();
      summary.match_found    = found;
      summary.match_offset   = found ? found_at : 32'd0;
      summary.longest_length = best_len;
      summary.longest_offset = best_at;
      awaited_summaries.push_back(summary);
      if (found) n_matches++;
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side: inputs change on the falling edge, beats are taken on the
  // rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      push = 1'b0;
      @(negedge clk);
    end
    push                = 1'b1;
    in_item.text_byte   = b;
    in_item.end_of_text = last;
    // hold the beat until the unit has room for it
    @(posedge clk);
    while (full) @(posedge clk);
    scan_text_byte(in_item);
    n_bytes++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_buf.size(); i++)
      send_byte(stream_buf[i], i == stream_buf.size() - 1);
    n_streams++;
  endtask

  // Let every awaited summary arrive, then give the unit a few quiet cycles
  // before the registers are touched.
  task automatic settle();
    while (awaited_summaries.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [63:0] value);
    cfg_write = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (which)
      REG_TARGET_LOW:  tgt_bytes[63:0]   = value;
      REG_TARGET_HIGH: tgt_bytes[127:64] = value;
      REG_TARGET_LEN:  tgt_len           = value[4:0];
      default: ;
    endcase
  endtask

  task automatic load_target(input logic [127:0] bytes, input logic [63:0] len_word);
    settle();
    write_reg(REG_TARGET_LOW, bytes[63:0]);
    write_reg(REG_TARGET_HIGH, bytes[127:64]);
    write_reg(REG_TARGET_LEN, len_word);
    n_targets++;
  endtask

  // ---------------------------------------------------------------------------
  // Stream builders.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0: b = 8'($urandom_range(128, 255));
      1: b = 8'($urandom_range(0, 8));      // NUL and low control bytes
      2: b = 8'($urandom_range(48, 57));
      3: b = 8'($urandom_range(65, 90));
      4: b = $urandom_range(0, 1) ? 8'd127 : 8'($urandom_range(14, 31));
      default: b = 8'($urandom_range(97, 99));  // narrow alphabet, many near misses
    endcase
    return b;
  endfunction

  function automatic logic [7:0] gap_byte();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = 8'($urandom_range(9, 13));
      1: b = 8'($urandom_range(32, 47));
      2: b = 8'($urandom_range(58, 64));
      3: b = 8'($urandom_range(91, 96));
      default: b = 8'($urandom_range(123, 126));
    endcase
    return b;
  endfunction

  task automatic add_gap();
    repeat ($urandom_range(1, 3)) stream_buf.push_back(gap_byte());
  endtask

  // One word: mostly copies of the target, one byte short or long, or with a
  // byte swapped, so that the comparison is exercised; the rest is random.
  task automatic add_word();
    int  tl;
    int  n;
    int  flip;
    logic copy;
    tl   = int'(tgt_len);
    flip = -1;
    copy = 1'b1;
    case ($urandom_range(0, 9))
      0, 1, 2: n = tl;
      3: n = tl + 1;
      4: n = tl - 1;
      5: begin
        n    = tl;
        flip = (tl > 0) ? $urandom_range(0, tl - 1) : -1;
      end
      9: begin
        n    = $urandom_range(12, 40);
        copy = 1'b0;
      end
      default: begin
        n    = $urandom_range(1, 10);
        copy = 1'b0;
      end
    endcase
    if (n < 1) begin
      n    = $urandom_range(1, 6);
      copy = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      if (copy) stream_buf.push_back(i < 16 ? tgt_bytes[8*i +: 8] : 8'h00);
      else stream_buf.push_back(word_byte());
    end
    if (flip >= 0) stream_buf[stream_buf.size() - n + flip] = word_byte();
  endtask

  task automatic build_stream();
    int words;
    stream_buf.delete();
    // a few streams are raw noise with no structure at all
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 24)) stream_buf.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 2) == 0) add_gap();
    words = $urandom_range(0, 3);
    for (int w = 0; w < words; w++) begin
      if (w > 0) add_gap();
      add_word();
    end
    // end on a separator or leave the last word open at the final byte
    if ($urandom_range(0, 1) == 1 || stream_buf.size() == 0) add_gap();
  endtask

  task automatic pick_target();
    logic [127:0] bytes;
    logic [63:0]  len_word;
    logic [31:0]  junk_hi;
    logic [31:0]  junk_lo;
    int           len;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = 16;
      2: len = $urandom_range(17, 31);   // too long to ever match
      default: len = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < 16; i++) bytes[8*i +: 8] = word_byte();
    case ($urandom_range(0, 7))
      0: bytes = {$urandom, $urandom, $urandom, $urandom};
      1: bytes = '0;
      default: ;
    endcase
    len_word = 64'(len);
    // junk above the length field must be dropped by the unit
    if ($urandom_range(0, 3) == 0) begin
      junk_hi  = $urandom;
      junk_lo  = $urandom;
      len_word = {junk_hi, junk_lo[26:0], 5'(len)};
    end
    load_target(bytes, len_word);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Target length is zero out of reset: nothing matches; the tie between two
  // words of two bytes keeps the first.
  task automatic test_default_target();
    stream_buf = '{"a", "b", " ", "c", "d"};
    send_stream();
  endtask

  // A stream that holds no word at all.
  task automatic test_empty_text();
    stream_buf = '{"."};
    send_stream();
  endtask

  // "cat" against "cats,cat": the longer word must not match, the word left
  // open at the final byte must.
  task automatic test_whole_word_match();
    load_target(128'h746163, 64'd3);
    stream_buf = '{"c", "a", "t", "s", ",", "c", "a", "t"};
    send_stream();
  endtask

  // Target of NUL then 0xFF with every other register bit set: a NUL is a word
  // byte, and a longer word that starts the same way is no match.
  task automatic test_binary_target();
    load_target({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00}, 64'd2);
    stream_buf = '{8'h00, 8'hFF, 8'h7F, 8'h20, 8'h00, 8'hFF};
    send_stream();
  endtask

  task automatic test_random_streams();
    int first_byte;
    int first_stream;
    first_byte   = n_bytes;
    first_stream = n_streams;
    while (n_bytes - first_byte < RANDOM_BYTES || n_streams - first_stream < MIN_STREAMS) begin
      if ((n_streams - first_stream) % 6 == 0) pick_target();
      sender_idles = ($urandom_range(0, 3) != 0);
      build_stream();
      send_stream();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: draw a stall per beat, take the beat on the rising edge and
  // compare it with the oldest awaited summary.
  // ---------------------------------------------------------------------------
  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (want === got) return;
    n_mismatches++;
    if (n_mismatches <= MAX_REPORTS)
      $display("%0t ns: result %0d %s expected 0x%0h got 0x%0h",
               $time, n_results, what, want, got);
  endtask

  task automatic check_summary(input result_t got);
    result_t want;
    if (awaited_summaries.size() == 0) begin
      n_mismatches++;
      if (n_mismatches <= MAX_REPORTS)
        $display("%0t ns: result beat with nothing awaited: found %0b at 0x%0h, longest %0d at 0x%0h",
                 $time, got.match_found, got.match_offset, got.longest_length,
                 got.longest_offset);
    end else begin
      want = awaited_summaries.pop_front();
      report_field("match_found", 32'(want.match_found), 32'(got.match_found));
      report_field("match_offset", want.match_offset, got.match_offset);
      report_field("longest_length", want.longest_length, got.longest_length);
      report_field("longest_offset", want.longest_offset, got.longest_offset);
    end
    n_results++;
  endtask

  initial begin : result_reader
    int stall;
    pop          = 1'b0;
    reader_idles = 1'b1;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      // swap between stalling and draining flat out every few beats
      if (n_results % 6 == 0) reader_idles = ($urandom_range(0, 2) != 0);
      stall = reader_idles ? $urandom_range(0, 11) : 0;
      repeat (stall) begin
        pop = 1'b0;
        @(negedge clk);
      end
      pop = 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_summary(out_item);
      @(negedge clk);
      pop = 1'b0;
    end
  end

  // Watchdog: drop the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst === 1'b1 || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Stalled for %0d cycles with %0d summaries awaited",
               idle_cycles, awaited_summaries.size());
      $display("word_stream_search_longest_unit verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst          = 1'b1;
    push         = 1'b0;
    in_item      = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_TARGET_LOW;
    cfg_data     = '0;
    tgt_bytes    = '0;
    tgt_len      = '0;
    sender_idles = 1'b1;
    n_bytes      = 0;
    n_streams    = 0;
    n_targets    = 0;
    n_results    = 0;
    n_matches    = 0;
    n_mismatches = 0;
    idle_cycles  = 0;
    clear_scan();
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_default_target();
    test_empty_text();
    test_whole_word_match();
    test_binary_target();
    test_random_streams();

    // drain, then leave a few quiet cycles to catch any stray result beat
    while (awaited_summaries.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Scanned %0d text bytes in %0d streams across %0d target settings",
             n_bytes, n_streams, n_targets);
    $display("Compared %0d summary beats, %0d of them with a whole-word match; %0d mismatches",
             n_results, n_matches, n_mismatches);
    if (n_mismatches == 0 && awaited_summaries.size() == 0) begin
      $display("word_stream_search_longest_unit verification clean");
    end else begin
      $display("word_stream_search_longest_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wssl_pkg.sv
rtl/wssl_front.sv
rtl/wssl_queue.sv
rtl/wssl_back.sv
rtl/word_stream_search_longest_unit.sv
rtl/wssl_checker.sv
verif/word_stream_search_longest_unit_test.sv
